// ===== sv/ssfm_pkg.sv =====
package ssfm_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int WINDOW_DEPTH      = MAX_PATTERN_BYTES - 1;
    localparam int PATTERN_SLOTS     = 32;
    localparam int PAT_IDX_W         = 5;
    localparam int LEN_W             = 6;
    localparam int COUNT_W           = 32;
    localparam int CFG_WORDS         = 4;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0_7   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_8_15  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_16_23 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_24_31 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH    = 3'd4;

    typedef struct packed {
        logic [PATTERN_SLOTS-1:0][7:0] bytes;
        logic [LEN_W-1:0]              len;
    } t_pattern;

    typedef struct packed {
        logic               emit;
        logic               found;
        logic [COUNT_W-1:0] offset;
    } t_step_res;

endpackage

// ===== sv/ssfm_cfg.sv =====
module ssfm_cfg
    import ssfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_pattern              o_pattern
);

    logic [CFG_WORDS-1:0][CFG_DATA_W-1:0] r_words;
    logic [LEN_W-1:0]                     r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words <= '0;
            r_len   <= '0;
        end else if (i_wr) begin
            unique case (i_index)
                CFG_PAT_0_7:   r_words[0] <= i_data;
                CFG_PAT_8_15:  r_words[1] <= i_data;
                CFG_PAT_16_23: r_words[2] <= i_data;
                CFG_PAT_24_31: r_words[3] <= i_data;
                CFG_LENGTH:    r_len      <= i_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_pattern.bytes = r_words;
    assign o_pattern.len   = r_len;

endmodule

// ===== sv/ssfm_engine.sv =====
module ssfm_engine
    import ssfm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic [7:0] i_byte,
    input  logic      i_last,
    input  t_pattern  i_pattern,
    output t_step_res o_res
);

    logic [WINDOW_DEPTH-1:0][7:0] r_window;
    logic [COUNT_W-1:0]           r_count;
    logic                         r_matched;

    logic [MAX_PATTERN_BYTES-1:0][7:0] w_view;
    logic [MAX_PATTERN_BYTES-1:0]      w_ok;
    logic                              w_overflow;
    logic [COUNT_W-1:0]                n_count;
    logic                              w_len_ok;
    logic                              w_hit;

    always_comb begin
        logic [LEN_W-1:0] idx_full;
        w_view[0] = i_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
            w_view[k] = r_window[k-1];
        end
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            idx_full = i_pattern.len - LEN_W'(1) - LEN_W'(k);
            w_ok[k]  = (LEN_W'(k) >= i_pattern.len) ||
                       (i_pattern.bytes[idx_full[PAT_IDX_W-1:0]] == w_view[k]);
        end
    end

    assign w_overflow = (r_count == COUNT_MAX);
    assign n_count    = w_overflow ? COUNT_MAX : r_count + COUNT_W'(1);
    assign w_len_ok   = (i_pattern.len != '0) &&
                        (i_pattern.len <= LEN_W'(MAX_PATTERN_BYTES)) &&
                        (n_count >= COUNT_W'(i_pattern.len));
    assign w_hit      = !r_matched && w_len_ok && (&w_ok);

    assign o_res.emit   = !r_matched && (w_hit || i_last);
    assign o_res.found  = w_hit;
    assign o_res.offset = !w_hit     ? '0 :
                          w_overflow ? COUNT_MAX :
                                       n_count - COUNT_W'(i_pattern.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_matched <= 1'b0;
        end else if (i_adv) begin
            if (i_last) begin
                r_count   <= '0;
                r_matched <= 1'b0;
            end else if (!r_matched) begin
                r_count   <= n_count;
                r_matched <= w_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && !i_last) begin
            r_window[0] <= i_byte;
            for (int k = 1; k < WINDOW_DEPTH; k++) begin
                r_window[k] <= r_window[k-1];
            end
        end
    end

endmodule

// ===== sv/substring_search_first_match.sv =====
// Channel   Direction  Request                 Fields (tdata / tuser)
// s_axis    in         one text byte           tdata: text_byte[7:0]; tlast: end_of_text
// m_axis    out        one search result       tdata: match_offset[31:0]; tuser: found
// cfg       in         one register write      index 0-3 pattern words, 4 pattern length
//
// One byte a cycle while the result register is not stalled: a byte is held in the
// input register, then one compare of the whole 32-byte window sets the result register.
// At most one result per text; a byte that gives none is still consumed.
// Reset clears the pattern, byte count, match flag and both valid flags.
// A stalled result holds the byte behind it; one byte further back stalls input.
module substring_search_first_match
    import ssfm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] text_byte
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [COUNT_W-1:0]    m_axis_tdata,   // [31:0] match_offset
    output logic                  m_axis_tuser,   // [0] found
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    logic               r_in_last;
    logic               r_out_valid;
    logic               r_out_found;
    logic [COUNT_W-1:0] r_out_offset;

    logic      w_adv;
    t_pattern  w_pattern;
    t_step_res w_res;

    assign o_cfg_ready   = 1'b1;
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    ssfm_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (i_cfg_valid),
        .i_index   (i_cfg_index),
        .i_data    (i_cfg_data),
        .o_pattern (w_pattern)
    );

    ssfm_engine u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_byte    (r_in_byte),
        .i_last    (r_in_last),
        .i_pattern (w_pattern),
        .o_res     (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.emit) begin
            r_out_found  <= w_res.found;
            r_out_offset <= w_res.offset;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_offset;
    assign m_axis_tuser  = r_out_found;

endmodule

// ===== sv/ssfm_checker.sv =====
module ssfm_checker
    import ssfm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [COUNT_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero offset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready && o_cfg_ready)
        else $error("not idle after reset");

endmodule

bind substring_search_first_match ssfm_checker u_ssfm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .o_cfg_ready   (o_cfg_ready)
);
